### rtl/core/paf_pkg.sv
`timescale 1ns / 1ps
package paf_pkg;

    localparam int BATCH_WORDS    = 16;
    localparam int PREAMBLE_WORDS = 18;
    localparam int CMDQ_DEPTH     = 2;

    localparam int CHAR_W  = 7;
    localparam int ACC_W   = 20;
    localparam int DATA_W  = 21;
    localparam int CHK_W   = 10;
    localparam int HELD_W  = 5;
    localparam int BP_W    = $clog2(BATCH_WORDS);
    localparam int WS_W    = $clog2(BATCH_WORDS + 1);
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 21;
    localparam int FUNC_W  = 2;

    localparam logic [31:0]       SYNC_WORD        = 32'h7CD215D8;
    localparam logic [31:0]       IDLE_WORD        = 32'h7A89C197;
    localparam logic [31:0]       PREAMBLE_PATTERN = 32'hAAAAAAAA;
    localparam logic [10:0]       BCH_GEN          = 11'b11101101001;
    localparam logic [DATA_W-1:0] MSG_FLAG         = 21'h100000;
    localparam logic [CHK_W-1:0]  CHECK_MASK       = 10'h3FF;
    localparam logic [FUNC_W-1:0] FUNC_RESET       = 2'd3;

    typedef logic [DATA_W-1:0][CHK_W-1:0] t_bch_cols;

    typedef struct packed {
        logic              first;
        logic              msg_ok;
        logic [ACC_W-1:0]  msg_data;
        logic              flush_ok;
        logic [ACC_W-1:0]  flush_data;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [FUNC_W-1:0] func;
    } t_cfg;

    function automatic t_bch_cols f_bch_cols();
        t_bch_cols   cols;
        logic [30:0] rem;
        logic [30:0] gen;
        for (int k = 0; k < DATA_W; k++) begin
            rem = 31'(1) << (k + CHK_W);
            gen = 31'(BCH_GEN) << 20;
            for (int col = 0; col < DATA_W; col++) begin
                if (rem[30 - col]) begin
                    rem = rem ^ gen;
                end
                gen = gen >> 1;
            end
            cols[k] = rem[CHK_W-1:0] & CHECK_MASK;
        end
        return cols;
    endfunction

    localparam t_bch_cols BCH_COLS = f_bch_cols();

    function automatic logic [31:0] f_codeword(logic [DATA_W-1:0] data);
        logic [CHK_W-1:0] chk;
        logic [30:0]      w;
        chk = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (data[i]) begin
                chk = chk ^ BCH_COLS[i];
            end
        end
        w = {data, chk};
        return {w, ^w};
    endfunction

endpackage

### rtl/core/paf_front.sv
`timescale 1ns / 1ps
module paf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [6:0]    i_char,
    input  logic          i_first,
    input  logic          i_last,
    input  logic          i_no_text,
    input  logic          i_full,
    output logic          o_push,
    output paf_pkg::t_cmd o_cmd
);
    import paf_pkg::*;

    localparam int SPLIT = ACC_W - CHAR_W;

    logic [ACC_W-1:0]        r_acc,  n_acc;
    logic [HELD_W-1:0]       r_held, n_held;
    logic [ACC_W-1:0]        acc0,   acc1;
    logic [HELD_W-1:0]       held0,  held1;
    logic [CHAR_W-1:0]       rev;
    logic [ACC_W+CHAR_W-1:0] ext;
    logic [2:0]              sh;
    logic                    accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        for (int j = 0; j < CHAR_W; j++) begin
            rev[j] = i_char[CHAR_W-1-j];
        end
        acc0  = i_first ? '0 : r_acc;
        held0 = i_first ? '0 : r_held;
        ext   = {acc0, rev};
        sh    = 3'(held0 - HELD_W'(SPLIT));
        o_cmd = '0;
        o_cmd.first = i_first;
        o_cmd.last  = i_last;
        acc1  = acc0;
        held1 = held0;
        priority if (!i_no_text && held0 >= HELD_W'(SPLIT)) begin
            o_cmd.msg_ok   = 1'b1;
            o_cmd.msg_data = ACC_W'(ext >> sh);
            acc1  = ACC_W'(rev & CHAR_W'((CHAR_W'(1) << sh) - CHAR_W'(1)));
            held1 = held0 - HELD_W'(SPLIT);
        end else if (!i_no_text) begin
            acc1  = ext[ACC_W-1:0];
            held1 = held0 + HELD_W'(CHAR_W);
        end else begin
            acc1  = acc0;
            held1 = held0;
        end
        o_cmd.flush_ok   = i_last && (held1 != '0);
        o_cmd.flush_data = ACC_W'(acc1 << (HELD_W'(ACC_W) - held1));
        n_acc  = r_acc;
        n_held = r_held;
        if (accept) begin
            n_acc  = i_last ? '0 : acc1;
            n_held = i_last ? '0 : held1;
        end
    end

    assign o_push = accept && (i_first || o_cmd.msg_ok || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

endmodule

### rtl/core/paf_cmdq.sv
`timescale 1ns / 1ps
module paf_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  paf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output paf_pkg::t_cmd o_cmd
);
    import paf_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QC_W  = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [QC_W-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == QC_W'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/core/paf_back.sv
`timescale 1ns / 1ps
module paf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  paf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  paf_pkg::t_cfg i_cfg,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_word,
    output logic          o_final
);
    import paf_pkg::*;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_PRE        = 4'd1;
    localparam logic [3:0] ST_SYNC       = 4'd2;
    localparam logic [3:0] ST_PREFIX     = 4'd3;
    localparam logic [3:0] ST_ADDR       = 4'd4;
    localparam logic [3:0] ST_MSG        = 4'd5;
    localparam logic [3:0] ST_MSG_SYNC   = 4'd6;
    localparam logic [3:0] ST_FLUSH      = 4'd7;
    localparam logic [3:0] ST_FLUSH_SYNC = 4'd8;
    localparam logic [3:0] ST_END        = 4'd9;
    localparam logic [3:0] ST_PAD        = 4'd10;

    localparam logic [BP_W-1:0] BP_LAST = BP_W'(BATCH_WORDS - 1);
    localparam logic [WS_W-1:0] WS_LAST = WS_W'(BATCH_WORDS);

    logic [3:0]       r_st,    n_st,  e_st;
    t_cmd             r_cmd,   n_cmd;
    logic [CNT_W-1:0] r_cnt,   n_cnt, e_cnt;
    logic [BP_W-1:0]  r_bp,    n_bp,  e_bp;
    logic [WS_W-1:0]  r_ws,    n_ws,  ws_inc;
    logic             r_ov,    n_ov;
    logic [31:0]      r_word,  n_word, e_word;
    logic             r_final, n_final, e_fin;
    logic             e_counted;
    logic             adv;
    logic [BP_W-1:0]  prefix;

    function automatic logic [3:0] f_after_flush(t_cmd c);
        return c.last ? ST_END : ST_IDLE;
    endfunction

    function automatic logic [3:0] f_after_msg(t_cmd c);
        return c.flush_ok ? ST_FLUSH : f_after_flush(c);
    endfunction

    function automatic logic [3:0] f_after_addr(t_cmd c);
        return c.msg_ok ? ST_MSG : f_after_msg(c);
    endfunction

    assign prefix = BP_W'({i_cfg.address[2:0], 1'b0});
    assign adv    = (r_st != ST_IDLE) && (!r_ov || i_ready);
    assign o_pop  = (r_st == ST_IDLE) && i_cmd_valid;
    assign ws_inc = (r_ws == WS_LAST) ? '0 : r_ws + WS_W'(1);

    always_comb begin
        e_word    = IDLE_WORD;
        e_fin     = 1'b0;
        e_counted = 1'b1;
        e_st      = r_st;
        e_cnt     = r_cnt;
        e_bp      = r_bp;
        unique case (r_st)
            ST_IDLE: begin
                e_counted = 1'b0;
            end
            ST_PRE: begin
                e_word    = PREAMBLE_PATTERN;
                e_counted = 1'b0;
                if (r_cnt == CNT_W'(PREAMBLE_WORDS - 1)) begin
                    e_st = ST_SYNC;
                end else begin
                    e_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_SYNC: begin
                e_word = SYNC_WORD;
                e_cnt  = '0;
                e_st   = (prefix != '0) ? ST_PREFIX : ST_ADDR;
            end
            ST_PREFIX: begin
                if (r_cnt == CNT_W'(prefix) - CNT_W'(1)) begin
                    e_st = ST_ADDR;
                end else begin
                    e_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_ADDR: begin
                e_word = f_codeword({1'b0, i_cfg.address[ADDR_W-1:3], i_cfg.func});
                e_bp   = prefix + BP_W'(1);
                e_st   = f_after_addr(r_cmd);
            end
            ST_MSG: begin
                e_word = f_codeword(MSG_FLAG | {1'b0, r_cmd.msg_data});
                e_bp   = r_bp + BP_W'(1);
                e_st   = (r_bp == BP_LAST) ? ST_MSG_SYNC : f_after_msg(r_cmd);
            end
            ST_MSG_SYNC: begin
                e_word = SYNC_WORD;
                e_st   = f_after_msg(r_cmd);
            end
            ST_FLUSH: begin
                e_word = f_codeword(MSG_FLAG | {1'b0, r_cmd.flush_data});
                e_bp   = r_bp + BP_W'(1);
                e_st   = (r_bp == BP_LAST) ? ST_FLUSH_SYNC : f_after_flush(r_cmd);
            end
            ST_FLUSH_SYNC: begin
                e_word = SYNC_WORD;
                e_st   = f_after_flush(r_cmd);
            end
            ST_END: begin
                e_bp = '0;
                e_st = ST_PAD;
            end
            ST_PAD: begin
                e_fin = (r_ws == WS_LAST);
                e_st  = e_fin ? ST_IDLE : ST_PAD;
            end
            default: begin
                e_counted = 1'b0;
                e_st      = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_st    = r_st;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_bp    = r_bp;
        n_ws    = r_ws;
        n_ov    = r_ov;
        n_word  = r_word;
        n_final = r_final;
        if (o_pop) begin
            n_cmd = i_cmd;
            n_cnt = '0;
            n_st  = i_cmd.first ? ST_PRE : f_after_addr(i_cmd);
            if (i_cmd.first) begin
                n_ws = '0;
            end
        end else if (adv) begin
            n_st  = e_st;
            n_cnt = e_cnt;
            n_bp  = e_bp;
            if (e_counted) begin
                n_ws = ws_inc;
            end
        end
        if (adv) begin
            n_ov    = 1'b1;
            n_word  = e_word;
            n_final = e_fin;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
            r_bp  <= '0;
            r_ws  <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_bp  <= n_bp;
            r_ws  <= n_ws;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_word  <= n_word;
        r_final <= n_final;
    end

    assign o_valid = r_ov;
    assign o_word  = r_word;
    assign o_final = r_final;

endmodule

### rtl/core/pocsag_alpha_frame_encoder.sv
`timescale 1ns / 1ps
// Throughput: the word engine emits one word per cycle unless m_axis_tready stalls it, and
// loads each request from the command queue in an idle step that emits no word;
// a header takes 20 + 2*(address bits 2..0) words. The two-entry command queue sets the slack.
// Reset is synchronous and active low: queue, packing and batch counters clear,
// address reads 0 and function code reads 3.
module pocsag_alpha_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [0] first_char, [1] no_text
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code_word
    output logic        m_axis_tlast,   // final_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import paf_pkg::*;

    t_cfg  r_cfg;
    t_cmd  w_push_cmd;
    t_cmd  w_head_cmd;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_cmd_valid;
    logic  w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? 32'(r_cfg.func) : 32'(r_cfg.address);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address <= '0;
            r_cfg.func    <= FUNC_RESET;
        end else if (w_wr) begin
            if (paddr[2]) begin
                r_cfg.func <= pwdata[FUNC_W-1:0];
            end else begin
                r_cfg.address <= pwdata[ADDR_W-1:0];
            end
        end
    end

    paf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_char    (s_axis_tdata[6:0]),
        .i_first   (s_axis_tuser[0]),
        .i_last    (s_axis_tlast),
        .i_no_text (s_axis_tuser[1]),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    paf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_head_cmd)
    );

    paf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .i_cfg       (r_cfg),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_word      (m_axis_tdata),
        .o_final     (m_axis_tlast)
    );

    a_final_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == IDLE_WORD)
        else $error("final word is not an idle word");

    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_cmd_valid)
        else $error("input stalled with an empty command queue");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_full |-> w_pop)
        else $error("push into a full command queue");

endmodule
